// ----- hw/rtl/grid_first_fit_rect_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the grid first-fit rectangle allocator.
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef GRID_FIRST_FIT_RECT_ALLOCATOR_DEFINES_SVH
`define GRID_FIRST_FIT_RECT_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GFFRA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GFFRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/gffra_pkg.sv -----
// ----------------------------------------------------------------------------
// gffra_pkg
// Shared constants, types and codes of the grid first-fit rectangle allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gffra_pkg;

   localparam int GRID_CELLS   = 64;
   localparam int CELL_PIXELS  = 4;
   localparam int MARGIN_CELLS = 2;

   localparam int IDX_W      = $clog2(GRID_CELLS);
   localparam int EXT_W      = IDX_W + 1;
   localparam int CFG_W      = 7;
   localparam int DIM_W      = 9;
   localparam int SIZE_W     = 8;
   localparam int ORG_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CELL_SHIFT = $clog2(CELL_PIXELS);

   typedef logic [IDX_W-1:0]      cell_idx_type;
   typedef logic [EXT_W-1:0]      extent_type;
   typedef logic [GRID_CELLS-1:0] row_type;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_XCHK,
      ST_SCAN,
      ST_MPREP,
      ST_MRD,
      ST_MWR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic         re;
      cell_idx_type raddr;
      logic         we;
      cell_idx_type waddr;
      row_type      wdata;
   } mem_cmd_type;

   typedef struct packed {
      logic             found;
      logic [ORG_W-1:0] origin_x;
      logic [ORG_W-1:0] origin_y;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/gffra_channels.sv -----
// ----------------------------------------------------------------------------
// gffra channels
// Valid/ready channel interfaces for requests, responses and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gffra_req_if;
   logic                         valid;
   logic                         ready;
   logic [gffra_pkg::DIM_W-1:0]  rect_width;
   logic [gffra_pkg::DIM_W-1:0]  rect_height;
   modport source (output valid, rect_width, rect_height, input ready);
   modport sink (input valid, rect_width, rect_height, output ready);
endinterface

interface gffra_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [gffra_pkg::ORG_W-1:0]  origin_x;
   logic [gffra_pkg::ORG_W-1:0]  origin_y;
   modport source (output valid, found, origin_x, origin_y, input ready);
   modport sink (input valid, found, origin_x, origin_y, output ready);
endinterface

interface gffra_csr_if;
   logic                             valid;
   logic                             ready;
   logic [gffra_pkg::CSR_IDX_W-1:0]  index;
   logic [gffra_pkg::CFG_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gffra_map_mem.sv -----
// ----------------------------------------------------------------------------
// gffra_map_mem
// Free map memory, one row of cells per word, with per-row valid bits so that
// a row never written reads as all free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gffra_map_mem (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gffra_pkg::mem_cmd_type cmd,
   output      gffra_pkg::row_type     rdata
);

   gffra_pkg::row_type                  mem [gffra_pkg::GRID_CELLS];
   logic [gffra_pkg::GRID_CELLS-1:0]    row_valid_ff;
   gffra_pkg::row_type                  rdata_ff;
   logic                                rvalid_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
      if (cmd.re) begin
         rdata_ff <= mem[cmd.raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rvalid_ff    <= 1'b0;
      end else begin
         if (cmd.we) begin
            row_valid_ff[cmd.waddr] <= 1'b1;
         end
         if (cmd.re) begin
            rvalid_ff <= row_valid_ff[cmd.raddr];
         end
      end
   end

   assign rdata = rvalid_ff ? rdata_ff : '1;

endmodule

`default_nettype wire

// ----- hw/rtl/gffra_engine.sv -----
// ----------------------------------------------------------------------------
// gffra_engine
// Search and mark sequencer: scans origins column by column over the map rows
// and clears the placed rectangle plus margin by read-modify-write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "grid_first_fit_rect_allocator_defines.svh"

module gffra_engine (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [gffra_pkg::DIM_W-1:0]    rect_width,
   input  wire logic [gffra_pkg::DIM_W-1:0]    rect_height,
   input  wire logic [gffra_pkg::CFG_W-1:0]    grid_cols,
   input  wire logic [gffra_pkg::CFG_W-1:0]    grid_rows,
   output      logic                           res_valid,
   input  wire logic                           res_take,
   output      gffra_pkg::result_type          result,
   output      gffra_pkg::mem_cmd_type         mem_cmd,
   input  wire gffra_pkg::row_type             mem_rdata
);

   localparam int M = gffra_pkg::MARGIN_CELLS;

   gffra_pkg::state_type                state_ff, state_in;
   gffra_pkg::extent_type               x_ff, x_in;
   gffra_pkg::cell_idx_type             yd_ff, yd_in;
   gffra_pkg::extent_type               run_ff, run_in;
   logic [gffra_pkg::SIZE_W-1:0]        w_ff, w_in;
   logic [gffra_pkg::SIZE_W-1:0]        h_ff, h_in;
   gffra_pkg::extent_type               cols_ff, cols_in;
   gffra_pkg::extent_type               rows_ff, rows_in;
   gffra_pkg::row_type                  win_ff, win_in;
   gffra_pkg::cell_idx_type             oy_ff, oy_in;
   gffra_pkg::row_type                  clr_ff, clr_in;
   gffra_pkg::cell_idx_type             r_ff, r_in;
   gffra_pkg::extent_type               rend_ff, rend_in;
   logic                                found_ff, found_in;

   logic [gffra_pkg::DIM_W:0]           wsum, hsum;
   logic [gffra_pkg::SIZE_W-1:0]        w_cells, h_cells;
   logic [gffra_pkg::SIZE_W:0]          x_plus_w;
   gffra_pkg::row_type                  shifted;
   logic                                win_ok;
   logic [gffra_pkg::SIZE_W:0]          cend, rend_raw;
   gffra_pkg::extent_type               cstart, rstart;
   logic [gffra_pkg::GRID_CELLS:0]      hi_mask, lo_mask, w_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gffra_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      yd_ff    <= yd_in;
      run_ff   <= run_in;
      w_ff     <= w_in;
      h_ff     <= h_in;
      cols_ff  <= cols_in;
      rows_ff  <= rows_in;
      win_ff   <= win_in;
      oy_ff    <= oy_in;
      clr_ff   <= clr_in;
      r_ff     <= r_in;
      rend_ff  <= rend_in;
      found_ff <= found_in;
   end

   always_comb begin
      wsum     = {1'b0, rect_width} + gffra_pkg::DIM_W'(gffra_pkg::CELL_PIXELS - 1);
      hsum     = {1'b0, rect_height} + gffra_pkg::DIM_W'(gffra_pkg::CELL_PIXELS - 1);
      w_cells  = gffra_pkg::SIZE_W'(wsum >> gffra_pkg::CELL_SHIFT);
      h_cells  = gffra_pkg::SIZE_W'(hsum >> gffra_pkg::CELL_SHIFT);
      w_mask   = ((gffra_pkg::GRID_CELLS+1)'(1) << ({1'b0, w_cells} + 9'd1))
                 - (gffra_pkg::GRID_CELLS+1)'(1);
      x_plus_w = {2'b00, x_ff} + {1'b0, w_ff};
      shifted  = mem_rdata >> x_ff[gffra_pkg::IDX_W-1:0];
      win_ok   = ((shifted & win_ff) == win_ff);
      cstart   = (x_ff >= gffra_pkg::EXT_W'(M)) ? x_ff - gffra_pkg::EXT_W'(M) : '0;
      rstart   = ({1'b0, oy_ff} >= gffra_pkg::EXT_W'(M)) ?
                 {1'b0, oy_ff} - gffra_pkg::EXT_W'(M) : '0;
      cend     = (x_plus_w + 9'(M) > {2'b00, cols_ff}) ? {2'b00, cols_ff} : x_plus_w + 9'(M);
      rend_raw = ({3'b000, oy_ff} + {1'b0, h_ff} + 9'(M) > {2'b00, rows_ff}) ?
                 {2'b00, rows_ff} : {3'b000, oy_ff} + {1'b0, h_ff} + 9'(M);
      hi_mask  = ((gffra_pkg::GRID_CELLS+1)'(1) << cend) - (gffra_pkg::GRID_CELLS+1)'(1);
      lo_mask  = ((gffra_pkg::GRID_CELLS+1)'(1) << cstart) - (gffra_pkg::GRID_CELLS+1)'(1);
   end

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      yd_in     = yd_ff;
      run_in    = run_ff;
      w_in      = w_ff;
      h_in      = h_ff;
      cols_in   = cols_ff;
      rows_in   = rows_ff;
      win_in    = win_ff;
      oy_in     = oy_ff;
      clr_in    = clr_ff;
      r_in      = r_ff;
      rend_in   = rend_ff;
      found_in  = found_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      mem_cmd   = '0;
      case (state_ff)
         gffra_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               w_in    = w_cells;
               h_in    = h_cells;
               win_in  = w_mask[gffra_pkg::GRID_CELLS-1:0];
               cols_in = (grid_cols > gffra_pkg::CFG_W'(gffra_pkg::GRID_CELLS)) ?
                         gffra_pkg::EXT_W'(gffra_pkg::GRID_CELLS) : grid_cols;
               rows_in = (grid_rows > gffra_pkg::CFG_W'(gffra_pkg::GRID_CELLS)) ?
                         gffra_pkg::EXT_W'(gffra_pkg::GRID_CELLS) : grid_rows;
               x_in    = '0;
               state_in = gffra_pkg::ST_XCHK;
            end
         end
         gffra_pkg::ST_XCHK: begin
            if (x_ff >= cols_ff || x_plus_w >= {2'b00, cols_ff} || rows_ff == '0) begin
               found_in = 1'b0;
               state_in = gffra_pkg::ST_DONE;
            end else begin
               mem_cmd.re    = 1'b1;
               mem_cmd.raddr = '0;
               yd_in    = '0;
               run_in   = '0;
               state_in = gffra_pkg::ST_SCAN;
            end
         end
         gffra_pkg::ST_SCAN: begin
            mem_cmd.re    = 1'b1;
            mem_cmd.raddr = yd_ff + 1'b1;
            run_in = win_ok ? run_ff + 1'b1 : '0;
            if (win_ok && {1'b0, run_ff} == h_ff) begin
               oy_in    = yd_ff - h_ff[gffra_pkg::IDX_W-1:0];
               found_in = 1'b1;
               state_in = gffra_pkg::ST_MPREP;
            end else if ({1'b0, yd_ff} == rows_ff - 1'b1) begin
               x_in     = x_ff + 1'b1;
               state_in = gffra_pkg::ST_XCHK;
            end else begin
               yd_in = yd_ff + 1'b1;
            end
         end
         gffra_pkg::ST_MPREP: begin
            clr_in   = hi_mask[gffra_pkg::GRID_CELLS-1:0] & ~lo_mask[gffra_pkg::GRID_CELLS-1:0];
            r_in     = rstart[gffra_pkg::IDX_W-1:0];
            rend_in  = rend_raw[gffra_pkg::EXT_W-1:0];
            state_in = gffra_pkg::ST_MRD;
         end
         gffra_pkg::ST_MRD: begin
            mem_cmd.re    = 1'b1;
            mem_cmd.raddr = r_ff;
            state_in      = gffra_pkg::ST_MWR;
         end
         gffra_pkg::ST_MWR: begin
            mem_cmd.we    = 1'b1;
            mem_cmd.waddr = r_ff;
            mem_cmd.wdata = mem_rdata & ~clr_ff;
            if ({1'b0, r_ff} + 1'b1 >= rend_ff) begin
               state_in = gffra_pkg::ST_DONE;
            end else begin
               r_in     = r_ff + 1'b1;
               state_in = gffra_pkg::ST_MRD;
            end
         end
         gffra_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = gffra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gffra_pkg::ST_IDLE;
         end
      endcase
   end

   assign result.found    = found_ff;
   assign result.origin_x = found_ff ?
      gffra_pkg::ORG_W'({x_ff, gffra_pkg::CELL_SHIFT'(0)}) : '0;
   assign result.origin_y = found_ff ?
      gffra_pkg::ORG_W'({oy_ff, gffra_pkg::CELL_SHIFT'(0)}) : '0;

   `GFFRA_ASSERT_SAME(a_scan_no_write, clock, reset, state_ff == gffra_pkg::ST_SCAN, !mem_cmd.we, "map written during scan")
   `GFFRA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff == gffra_pkg::ST_XCHK, "accepted request did not start a search")
   `GFFRA_ASSERT_SAME(a_found_in_grid, clock, reset, res_valid && found_ff, {2'b00, oy_ff} + {1'b0, h_ff} < {2'b00, rows_ff}, "placed rectangle exceeds grid rows")
   `GFFRA_ASSERT_SAME(a_mark_rows_in_grid, clock, reset, mem_cmd.we, {1'b0, mem_cmd.waddr} < rows_ff, "mark outside active rows")

endmodule

`default_nettype wire

// ----- hw/rtl/grid_first_fit_rect_allocator.sv -----
// ----------------------------------------------------------------------------
// grid_first_fit_rect_allocator
// First-fit rectangle placement over a free map of 4-pixel atlas cells.
// ----------------------------------------------------------------------------
// Each request takes one transaction and returns exactly one response. The
// search reads one map row per cycle for each candidate column, and a found
// place is then marked row by row with a read and a write of each row.
// The free map lives in a single-port-read, single-port-write memory with a
// registered read. The response sits in an output register, so the next
// request is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module grid_first_fit_rect_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   gffra_req_if.sink        req_ch,
   gffra_rsp_if.source      rsp_ch,
   gffra_csr_if.sink        csr_ch
);

   logic [gffra_pkg::CFG_W-1:0] grid_cols_ff, grid_rows_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   gffra_pkg::result_type       rsp_data_ff;
   gffra_pkg::result_type       result;
   gffra_pkg::mem_cmd_type      mem_cmd;
   gffra_pkg::row_type          mem_rdata;
   logic                        res_valid, res_take;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= gffra_pkg::CFG_W'(gffra_pkg::GRID_CELLS);
         grid_rows_ff <= gffra_pkg::CFG_W'(gffra_pkg::GRID_CELLS);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            gffra_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_ch.data;
            gffra_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   assign res_take     = res_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.found    = rsp_data_ff.found;
   assign rsp_ch.origin_x = rsp_data_ff.origin_x;
   assign rsp_ch.origin_y = rsp_data_ff.origin_y;

   gffra_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .rect_width  (req_ch.rect_width),
      .rect_height (req_ch.rect_height),
      .grid_cols   (grid_cols_ff),
      .grid_rows   (grid_rows_ff),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .result      (result),
      .mem_cmd     (mem_cmd),
      .mem_rdata   (mem_rdata)
   );

   gffra_map_mem u_map_mem (
      .clock (clock),
      .reset (reset),
      .cmd   (mem_cmd),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire
